// ----- hw/rtl/s3tc_pkg.sv -----
// Shared types, mode codes and fixed-divisor helpers of the S3TC block decoder.
`timescale 1ns / 1ps
`default_nettype none

package s3tc_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_DEPTH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ENCODING = 8'd1;

	localparam logic [1:0] MODE_DXT1 = 2'd0;
	localparam logic [1:0] MODE_DXT3 = 2'd1;
	localparam logic [1:0] MODE_DXT5 = 2'd2;

	localparam logic [19:0] RECIP3 = 20'd341;
	localparam logic [18:0] RECIP5 = 19'd409;
	localparam logic [18:0] RECIP7 = 19'd292;

	localparam logic [7:0] EXP5_LUT [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

	typedef struct packed {
		logic [63:0] color_block;
		logic [63:0] alpha_block;
	} s3tc_in_t;

	typedef struct packed {
		logic [1:0]  row_index;
		logic [31:0] pixel0;
		logic [31:0] pixel1;
		logic [31:0] pixel2;
		logic [31:0] pixel3;
		logic        last_row;
	} s3tc_out_t;

	typedef struct packed {
		logic [1:0]            mode;
		logic                  gt;
		logic [31:0]           idx;
		logic [63:0]           ab;
		logic [3:0][2:0][7:0]  pal;
		logic [7:0][7:0]       alph;
	} s3tc_blk_t;

	function automatic logic [7:0] exp5(input logic [4:0] x);
		return EXP5_LUT[x];
	endfunction

	// x * 255 / 63 == 4x + x / 21 exactly
	function automatic logic [7:0] exp6(input logic [5:0] x);
		logic [1:0] f;
		f = (x == 6'd63) ? 2'd3 : (x >= 6'd42) ? 2'd2 : (x >= 6'd21) ? 2'd1 : 2'd0;
		return {x, 2'b00} + {6'd0, f};
	endfunction

	function automatic logic [7:0] div3_est(input logic [9:0] n);
		logic [19:0] p;
		p = {10'd0, n} * RECIP3;
		return p[17:10];
	endfunction

	function automatic logic [7:0] div3_fix(input logic [9:0] n, input logic [7:0] est);
		logic [9:0] r;
		r = n - ({2'd0, est} * 10'd3);
		return (r >= 10'd3) ? est + 8'd1 : est;
	endfunction

	function automatic logic [7:0] div5_est(input logic [10:0] n);
		logic [18:0] p;
		p = {8'd0, n} * RECIP5;
		return p[18:11];
	endfunction

	function automatic logic [7:0] div5_fix(input logic [10:0] n, input logic [7:0] est);
		logic [10:0] r;
		r = n - ({3'd0, est} * 11'd5);
		return (r >= 11'd5) ? est + 8'd1 : est;
	endfunction

	function automatic logic [7:0] div7_est(input logic [10:0] n);
		logic [18:0] p;
		p = {8'd0, n} * RECIP7;
		return p[18:11];
	endfunction

	function automatic logic [7:0] div7_fix(input logic [10:0] n, input logic [7:0] est);
		logic [10:0] r;
		r = n - ({3'd0, est} * 11'd7);
		return (r >= 11'd7) ? est + 8'd1 : est;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/s3tc_pal_pipe.sv -----
// Four-stage pipeline that turns a compressed block into its color palette and alpha table.
`timescale 1ns / 1ps
`default_nettype none

module s3tc_pal_pipe
	import s3tc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire s3tc_in_t  in_data,
	input  wire logic [1:0] in_mode,
	output logic           out_valid,
	input  wire logic      out_ready,
	output s3tc_blk_t      out_blk
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [63:0] cb_s1, ab_s1;
	logic [1:0]  mode_s1;

	logic [2:0][7:0]  e0_s2, e1_s2, e0_d, e1_d;
	logic [2:0][9:0]  num2_s2, num3_s2, num2_d, num3_d;
	logic [5:0][10:0] anum_s2, anum_d;
	logic             gt_s2, agt_s2;
	logic [7:0]       a0_s2, a1_s2;
	logic [31:0]      idx_s2;
	logic [63:0]      ab_s2;
	logic [1:0]       mode_s2;

	logic [2:0][7:0]  e0_s3, e1_s3, est2_s3, est3_s3, est2_d, est3_d;
	logic [2:0][9:0]  num2_s3, num3_s3;
	logic [5:0][10:0] anum_s3;
	logic [5:0][7:0]  aest_s3, aest_d;
	logic             gt_s3, agt_s3;
	logic [7:0]       a0_s3, a1_s3;
	logic [31:0]      idx_s3;
	logic [63:0]      ab_s3;
	logic [1:0]       mode_s3;

	s3tc_blk_t blk_s4, blk_d;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign out_valid = v_s4;
	assign out_blk   = blk_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			cb_s1   <= in_data.color_block;
			ab_s1   <= in_data.alpha_block;
			mode_s1 <= in_mode;
		end
	end

	always_comb begin
		logic [7:0] a0, a1;
		logic       agt;
		a0 = ab_s1[7:0];
		a1 = ab_s1[15:8];
		agt = a0 > a1;
		e0_d[0] = exp5(cb_s1[15:11]);
		e0_d[1] = exp6(cb_s1[10:5]);
		e0_d[2] = exp5(cb_s1[4:0]);
		e1_d[0] = exp5(cb_s1[31:27]);
		e1_d[1] = exp6(cb_s1[26:21]);
		e1_d[2] = exp5(cb_s1[20:16]);
		for (int c = 0; c < 3; c++) begin
			num2_d[c] = (cb_s1[15:0] > cb_s1[31:16]) ?
				{1'b0, e0_d[c], 1'b0} + {2'd0, e1_d[c]} :
				{2'd0, e0_d[c]} + {2'd0, e1_d[c]};
			num3_d[c] = {2'd0, e0_d[c]} + {1'b0, e1_d[c], 1'b0};
		end
		for (int i = 0; i < 6; i++) begin
			if (agt)
				anum_d[i] = 11'(6 - i) * {3'd0, a0} + 11'(1 + i) * {3'd0, a1};
			else if (i < 4)
				anum_d[i] = 11'(4 - i) * {3'd0, a0} + 11'(1 + i) * {3'd0, a1};
			else
				anum_d[i] = 11'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			e0_s2   <= e0_d;
			e1_s2   <= e1_d;
			num2_s2 <= num2_d;
			num3_s2 <= num3_d;
			anum_s2 <= anum_d;
			gt_s2   <= cb_s1[15:0] > cb_s1[31:16];
			agt_s2  <= ab_s1[7:0] > ab_s1[15:8];
			a0_s2   <= ab_s1[7:0];
			a1_s2   <= ab_s1[15:8];
			idx_s2  <= cb_s1[63:32];
			ab_s2   <= ab_s1;
			mode_s2 <= mode_s1;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			est2_d[c] = div3_est(num2_s2[c]);
			est3_d[c] = div3_est(num3_s2[c]);
		end
		for (int i = 0; i < 6; i++)
			aest_d[i] = agt_s2 ? div7_est(anum_s2[i]) : div5_est(anum_s2[i]);
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			e0_s3   <= e0_s2;
			e1_s3   <= e1_s2;
			num2_s3 <= num2_s2;
			num3_s3 <= num3_s2;
			est2_s3 <= est2_d;
			est3_s3 <= est3_d;
			anum_s3 <= anum_s2;
			aest_s3 <= aest_d;
			gt_s3   <= gt_s2;
			agt_s3  <= agt_s2;
			a0_s3   <= a0_s2;
			a1_s3   <= a1_s2;
			idx_s3  <= idx_s2;
			ab_s3   <= ab_s2;
			mode_s3 <= mode_s2;
		end
	end

	always_comb begin
		blk_d.mode = mode_s3;
		blk_d.gt   = gt_s3;
		blk_d.idx  = idx_s3;
		blk_d.ab   = ab_s3;
		for (int c = 0; c < 3; c++) begin
			blk_d.pal[0][c] = e0_s3[c];
			blk_d.pal[1][c] = e1_s3[c];
			blk_d.pal[2][c] = gt_s3 ? div3_fix(num2_s3[c], est2_s3[c]) : num2_s3[c][8:1];
			blk_d.pal[3][c] = gt_s3 ? div3_fix(num3_s3[c], est3_s3[c]) : 8'd0;
		end
		blk_d.alph[0] = a0_s3;
		blk_d.alph[1] = a1_s3;
		for (int i = 0; i < 6; i++) begin
			if (agt_s3)
				blk_d.alph[2 + i] = div7_fix(anum_s3[i], aest_s3[i]);
			else if (i < 4)
				blk_d.alph[2 + i] = div5_fix(anum_s3[i], aest_s3[i]);
			else if (i == 4)
				blk_d.alph[2 + i] = 8'd0;
			else
				blk_d.alph[2 + i] = 8'd255;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4)
			blk_s4 <= blk_d;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/s3tc_block_decoder_top.sv -----
// Top level of the S3TC block decoder: config registers, palette pipeline and row output.
//
//  channel | direction | handshake            | payload
//  src     | in        | src_valid / src_stall | s3tc_in_t  (color_block, alpha_block)
//  dst     | out       | dst_valid / dst_stall | s3tc_out_t (row_index, pixel0..3, last_row)
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Row 0 of a block shows on dst after the block passes the palette pipeline stages,
// the block register and the row register on dst. Each block leaves as four beats, one per
// cycle while dst is not stalled; the block register holds one block until its last row loads, then takes the next.
// Reset clears all valid bits and both config registers; cfg_ready stays high.
// A stall on dst backs up through the pipeline stages; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module s3tc_block_decoder_top
	import s3tc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  src_valid,
	output logic                       src_stall,
	input  wire s3tc_in_t              src_data,
	output logic                       dst_valid,
	input  wire logic                  dst_stall,
	output s3tc_out_t                  dst_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [7:0] alpha_depth_q, alpha_encoding_q;
	logic [1:0] mode;
	logic       pipe_ready, pipe_valid, blk_take;
	s3tc_blk_t  pipe_blk;

	s3tc_blk_t  blk_q;
	logic       blk_valid_q;
	logic [1:0] row_q;
	s3tc_out_t  out_q, row_d;
	logic       out_valid_q, out_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_depth_q    <= 8'd0;
			alpha_encoding_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ALPHA_DEPTH)
				alpha_depth_q <= cfg_data;
			else if (cfg_index == REG_ALPHA_ENCODING)
				alpha_encoding_q <= cfg_data;
		end
	end

	always_comb begin
		if (alpha_depth_q == 8'd0 || (alpha_depth_q == 8'd1 && alpha_encoding_q == 8'd0))
			mode = MODE_DXT1;
		else if (alpha_depth_q == 8'd4 || (alpha_depth_q == 8'd8 && alpha_encoding_q == 8'd1))
			mode = MODE_DXT3;
		else if (alpha_depth_q == 8'd8 && alpha_encoding_q == 8'd7)
			mode = MODE_DXT5;
		else
			mode = MODE_DXT1;
	end

	s3tc_pal_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (src_valid),
		.in_ready  (pipe_ready),
		.in_data   (src_data),
		.in_mode   (mode),
		.out_valid (pipe_valid),
		.out_ready (blk_take),
		.out_blk   (pipe_blk)
	);

	assign src_stall = !pipe_ready;

	assign out_load = blk_valid_q && (!out_valid_q || !dst_stall);
	assign blk_take = !blk_valid_q || (out_load && row_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_valid_q <= 1'b0;
			row_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pipe_valid && blk_take) begin
				blk_valid_q <= 1'b1;
				row_q       <= 2'd0;
			end else if (out_load) begin
				if (row_q == 2'd3)
					blk_valid_q <= 1'b0;
				row_q <= row_q + 2'd1;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!dst_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_valid && blk_take)
			blk_q <= pipe_blk;
		if (out_load)
			out_q <= row_d;
	end

	always_comb begin
		logic [3:0]       t;
		logic [1:0]       k;
		logic [3:0]       an;
		logic [2:0]       ai;
		logic [7:0]       a;
		logic [3:0][31:0] px;
		for (int x = 0; x < 4; x++) begin
			t  = {row_q, 2'(x)};
			k  = blk_q.idx[{t, 1'b0} +: 2];
			an = blk_q.ab[{t, 2'b00} +: 4];
			ai = blk_q.ab[6'd16 + 6'(t) * 6'd3 +: 3];
			case (blk_q.mode)
				MODE_DXT3: a = {an, an};
				MODE_DXT5: a = blk_q.alph[ai];
				default:   a = (k == 2'd3 && !blk_q.gt) ? 8'd0 : 8'd255;
			endcase
			px[x] = {a, blk_q.pal[k][2], blk_q.pal[k][1], blk_q.pal[k][0]};
		end
		row_d.row_index = row_q;
		row_d.pixel0    = px[0];
		row_d.pixel1    = px[1];
		row_d.pixel2    = px[2];
		row_d.pixel3    = px[3];
		row_d.last_row  = row_q == 2'd3;
	end

	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/s3tc_checker.sv -----
// Port-level checker for the S3TC block decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module s3tc_checker
	import s3tc_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      dst_valid,
	input wire logic      dst_stall,
	input wire s3tc_out_t dst_data
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
		else $error("stalled dst beat changed");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> dst_data.last_row == (dst_data.row_index == 2'd3))
		else $error("last_row does not match row_index");

	a_row_advance: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_stall && !dst_data.last_row |=>
			dst_valid && dst_data.row_index == $past(dst_data.row_index) + 2'd1)
		else $error("rows of a block not back to back");

	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_stall && dst_data.last_row |=>
			!dst_valid || dst_data.row_index == 2'd0)
		else $error("block does not start at row 0");

endmodule

bind s3tc_block_decoder_top s3tc_checker u_s3tc_checker (.*);

`default_nettype wire
